[sv/assert_macros.svh]
// Assertion macros shared by the frame cache RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame cache assertion failed");

// Next-cycle implication, disabled during reset.
`define FCRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame cache assertion failed");

`endif

[sv/fcrp_pkg.sv]
// Types and constants of the frame cache replacement block.
package fcrp_pkg;

  localparam int KEY_WIDTH = 32;
  localparam int DEPTH_DEF = 16;
  localparam int CFG_W     = 5;
  localparam int CNT_OUT_W = 5;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_NA     = 2'd2;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] frame_key;
    logic                 source_available;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 evicted;
    logic [KEY_WIDTH-1:0] evicted_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_t;

endpackage

[sv/fcrp_key_ram.sv]
// Single-port-write, single-read key store with registered read data.
module fcrp_key_ram #(
  parameter int DEPTH = fcrp_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [fcrp_pkg::KEY_WIDTH-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [fcrp_pkg::KEY_WIDTH-1:0] wr_data
);

  logic [fcrp_pkg::KEY_WIDTH-1:0] mem [DEPTH];
  logic [fcrp_pkg::KEY_WIDTH-1:0] rd_data_r;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/frame_cache_replacement_policy.sv]
// Top level of the frame cache replacement block: sequencer around the key store.
//
// Pulse start while busy is low to hand in one request; busy stays high until
// the result is out. Each request yields exactly one result beat on out_result,
// marked by a one-cycle out_strobe that cannot be held off, so capture it on
// that cycle. The keys sit in a RAM read one entry per cycle, and that read
// port sets the timing: a hit searches the list up to its position h, a miss
// with f entries cached searches the whole list, then moves each entry back one
// slot, and a miss with no data available searches the whole list only.
// Write cfg_wdata with cfg_we only while busy is low; max_entries of 0 acts as
// 1 and values above DEPTH act as DEPTH.
`include "assert_macros.svh"

module frame_cache_replacement_policy #(
  parameter int DEPTH = fcrp_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  fcrp_pkg::in_t              in_item,
  output logic                       out_strobe,
  output fcrp_pkg::out_t             out_result,
  input  logic                       cfg_we,
  input  logic [fcrp_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > fcrp_pkg::CFG_W) ? CNT_W : fcrp_pkg::CFG_W;
  localparam int KW     = fcrp_pkg::KEY_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_HIT_A  = 3'd2;
  localparam logic [2:0] S_HIT_B  = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [KW-1:0]              key_r, key_nxt;
  logic                       avail_r, avail_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [ADDR_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic [fcrp_pkg::CFG_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]           src_cnt_r, src_cnt_nxt;
  logic                       mv_vld_r, mv_vld_nxt;
  logic [ADDR_W-1:0]          mv_dst_r, mv_dst_nxt;
  logic                       ev_r, ev_nxt;
  logic                       ev_cap_r, ev_cap_nxt;
  logic [KW-1:0]              ev_key_r, ev_key_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  fcrp_pkg::out_t             out_r, out_nxt;

  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [KW-1:0]              rd_data;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [KW-1:0]              wr_data;

  logic [CMP_W-1:0]           max_ext;
  logic [CMP_W-1:0]           eff_max;
  logic [CMP_W-1:0]           fill_ext;
  logic [CNT_W-1:0]           fill_m1;
  logic [CNT_W-1:0]           src_m1;
  logic                       hit_now;
  logic                       evict_now;
  logic [KW-1:0]              ev_key_cur;

  fcrp_key_ram #(
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    max_ext = CMP_W'(max_r);
    if (max_ext == '0) begin
      eff_max = CMP_W'(1);
    end else if (max_ext > CMP_W'(DEPTH)) begin
      eff_max = CMP_W'(DEPTH);
    end else begin
      eff_max = max_ext;
    end
  end

  assign fill_ext   = CMP_W'(fill_r);
  assign fill_m1    = fill_r - 1'b1;
  assign src_m1     = src_cnt_r - 1'b1;
  assign hit_now    = cmp_vld_r && (rd_data == key_r);
  assign evict_now  = (fill_ext >= eff_max) && (fill_r != '0);
  assign ev_key_cur = ev_cap_r ? rd_data : ev_key_r;

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    avail_nxt      = avail_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_idx_nxt    = hit_idx_r;
    fill_nxt       = fill_r;
    max_nxt        = cfg_we ? cfg_wdata : max_r;
    src_cnt_nxt    = src_cnt_r;
    mv_vld_nxt     = mv_vld_r;
    mv_dst_nxt     = mv_dst_r;
    ev_nxt         = ev_r;
    ev_cap_nxt     = ev_cap_r;
    ev_key_nxt     = ev_key_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = key_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt     = in_item.frame_key;
          avail_nxt   = in_item.source_available;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          ev_nxt      = 1'b0;
          ev_cap_nxt  = 1'b0;
          state_nxt   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit_now) begin
          hit_idx_nxt = cmp_idx_r;
          state_nxt   = S_HIT_A;
        end else if (idx_r != fill_r) begin
          // Issue the next read; compare it in the following cycle.
          rd_en       = 1'b1;
          rd_addr     = idx_r[ADDR_W-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[ADDR_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else if (!avail_r) begin
          out_nxt.status      = fcrp_pkg::ST_NA;
          out_nxt.evicted     = 1'b0;
          out_nxt.evicted_key = '0;
          out_nxt.entry_count = fill_ext[fcrp_pkg::CNT_OUT_W-1:0];
          out_strobe_nxt      = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          ev_nxt     = evict_now;
          mv_vld_nxt = 1'b0;
          if (evict_now) begin
            // Fetch the back entry before the shift overwrites it.
            rd_en       = 1'b1;
            rd_addr     = fill_m1[ADDR_W-1:0];
            ev_cap_nxt  = 1'b1;
            src_cnt_nxt = fill_m1;
            fill_nxt    = fill_r;
          end else begin
            src_cnt_nxt = fill_r;
            fill_nxt    = fill_r + 1'b1;
          end
          state_nxt = S_SHIFT;
        end
      end
      S_HIT_A: begin
        // Read the old front and put the hit key there in the same cycle.
        rd_en     = 1'b1;
        rd_addr   = '0;
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = key_r;
        state_nxt = S_HIT_B;
      end
      S_HIT_B: begin
        wr_en               = 1'b1;
        wr_addr             = hit_idx_r;
        wr_data             = rd_data;
        out_nxt.status      = fcrp_pkg::ST_HIT;
        out_nxt.evicted     = 1'b0;
        out_nxt.evicted_key = '0;
        out_nxt.entry_count = fill_ext[fcrp_pkg::CNT_OUT_W-1:0];
        out_strobe_nxt      = 1'b1;
        state_nxt           = S_IDLE;
      end
      S_SHIFT: begin
        ev_cap_nxt = 1'b0;
        ev_key_nxt = ev_key_cur;
        if (mv_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = mv_dst_r;
          wr_data = rd_data;
        end
        if (src_cnt_r != '0) begin
          // Move entry src-1 back to slot src, back to front.
          rd_en       = 1'b1;
          rd_addr     = src_m1[ADDR_W-1:0];
          mv_vld_nxt  = 1'b1;
          mv_dst_nxt  = src_cnt_r[ADDR_W-1:0];
          src_cnt_nxt = src_m1;
        end else begin
          mv_vld_nxt = 1'b0;
          if (!mv_vld_r) begin
            wr_en               = 1'b1;
            wr_addr             = '0;
            wr_data             = key_r;
            out_nxt.status      = fcrp_pkg::ST_INSERT;
            out_nxt.evicted     = ev_r;
            out_nxt.evicted_key = ev_r ? ev_key_cur : '0;
            out_nxt.entry_count = fill_ext[fcrp_pkg::CNT_OUT_W-1:0];
            out_strobe_nxt      = 1'b1;
            state_nxt           = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      max_r        <= fcrp_pkg::MAX_ENTRIES_RST;
      cmp_vld_r    <= 1'b0;
      mv_vld_r     <= 1'b0;
      ev_r         <= 1'b0;
      ev_cap_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      max_r        <= max_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      mv_vld_r     <= mv_vld_nxt;
      ev_r         <= ev_nxt;
      ev_cap_r     <= ev_cap_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    avail_r   <= avail_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    src_cnt_r <= src_cnt_nxt;
    mv_dst_r  <= mv_dst_nxt;
    ev_key_r  <= ev_key_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  `FCRP_ASSERT_IMP(a_strobe_idle, out_strobe_r, state_r == S_IDLE)
  `FCRP_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CNT_W'(DEPTH))
  `FCRP_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `FCRP_ASSERT_IMP(a_evict_insert, out_strobe_r && out_r.evicted,
                   out_r.status == fcrp_pkg::ST_INSERT)
  `FCRP_ASSERT_IMP(a_no_evict_key, out_strobe_r && !out_r.evicted, out_r.evicted_key == '0)

endmodule
